[hw/rtl/ring_test_pattern_generator_defines.svh]
// Assertion macros shared by the ring test pattern generator RTL.
// No dependencies; assertions compile away when SYNTHESIS is defined.
`ifndef RING_TEST_PATTERN_GENERATOR_DEFINES_SVH
`define RING_TEST_PATTERN_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RTPG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rtpg assertion failed");
// next-cycle implication
`define RTPG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rtpg assertion failed");
`else
`define RTPG_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RTPG_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[hw/rtl/rtpg_pkg.sv]
// Shared types and constants of the ring test pattern generator.
// No dependencies.
package rtpg_pkg;

    localparam int COORD_W = 12;
    localparam int PAD_W   = 10;
    localparam int TIME_W  = 32;
    localparam int STEP_W  = 6;
    localparam int ADDR_W  = 4;
    localparam int APB_W   = 32;

    // geometry and shading constants
    localparam int EDGE_GAP   = 8;
    localparam int RING_GAP   = 32;
    localparam int CROSS_HALF = 6;
    localparam int LOOP_HIGH  = 3200;
    localparam int LOOP_LOW   = 16;
    localparam int STEP_MAG   = 16;

    localparam logic [TIME_W-1:0]  PAD_VALUE   = 32'hffff_ffff;
    localparam logic [7:0]         ALPHA_ON    = 8'hff;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 6'b110000;   // -16
    localparam logic [COORD_W-1:0] WIDTH_RESET = 12'd1000;
    localparam logic [COORD_W-1:0] HEIGHT_RESET = 12'd1000;
    localparam logic [PAD_W-1:0]   PAD_RESET   = 10'd20;

    // register map, word index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_PAD_WIDTH    = 2'd2,
        REG_LOOP_MODE    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] frame_width;
        logic [COORD_W-1:0] frame_height;
        logic [PAD_W-1:0]   pad_width;
        logic               loop_mode;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEOM,
        ST_SQUARE,
        ST_SHADE,
        ST_FINISH
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic geom;
        logic square;
        logic shade;
        logic finish;
    } t_dp_cmd;

endpackage

[hw/rtl/ring_test_pattern_generator.sv]
// Ring test pattern generator: one pixel coordinate in, one XRGB word out.
// Usage:
//   s_axis carries one pixel request per transfer: tdata holds pix_x,
//   pix_y and host_time; tlast marks the last pixel of a frame.
//   m_axis returns the pixel's colour in tdata and echoes tlast.
//   The APB port sets frame size, border width and loop mode; write it
//   only while no pixel is in flight.
// Timing:
//   A request passes through the controller's sequence: capture,
//   geometry, squaring, shading, output. A new request is taken only
//   after the last one has left the output step.
//   The output register lets the next request be taken while a result
//   waits; a stalled receiver holds the block in its output step.
// Reset:
//   i_rst_n is synchronous, active low. It restores the register defaults
//   (1000 x 1000 frame, 20 pixel border, host time mode), clears the frame
//   time to zero and sets the loop step to -16. No result is pending.
// Depends on rtpg_pkg, rtpg_cfg, rtpg_ctrl and rtpg_dp.
module ring_test_pattern_generator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [55:0]                 s_axis_tdata,  // pix_x[11:0], pix_y[23:12], host_time[55:24]
    input  logic                        s_axis_tlast,  // frame_last
    // master stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata,  // pixel_value[31:0]
    output logic                        m_axis_tlast,  // frame_done
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rtpg_pkg::ADDR_W-1:0] paddr,
    input  logic [rtpg_pkg::APB_W-1:0]  pwdata,
    output logic [rtpg_pkg::APB_W-1:0]  prdata,
    output logic                        pready
);

    rtpg_pkg::t_cfg    cfg;
    rtpg_pkg::t_dp_cmd cmd;

    rtpg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rtpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    rtpg_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .i_pix_x       (s_axis_tdata[11:0]),
        .i_pix_y       (s_axis_tdata[23:12]),
        .i_frame_last  (s_axis_tlast),
        .i_host_time   (s_axis_tdata[55:24]),
        .o_pixel_value (m_axis_tdata),
        .o_frame_done  (m_axis_tlast)
    );

endmodule

[hw/rtl/rtpg_cfg.sv]
// APB register file of the ring test pattern generator.
// Depends on rtpg_pkg.
module rtpg_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rtpg_pkg::ADDR_W-1:0]   paddr,
    input  logic [rtpg_pkg::APB_W-1:0]    pwdata,
    output logic [rtpg_pkg::APB_W-1:0]    prdata,
    output logic                          pready,
    output rtpg_pkg::t_cfg                o_cfg
);

    rtpg_pkg::t_cfg   r_cfg;
    rtpg_pkg::t_reg_idx idx;
    logic             wr_en;

    assign idx    = rtpg_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= rtpg_pkg::WIDTH_RESET;
            r_cfg.frame_height <= rtpg_pkg::HEIGHT_RESET;
            r_cfg.pad_width    <= rtpg_pkg::PAD_RESET;
            r_cfg.loop_mode    <= 1'b0;
        end else if (wr_en) begin
            case (idx)
                rtpg_pkg::REG_FRAME_WIDTH:  r_cfg.frame_width  <= pwdata[rtpg_pkg::COORD_W-1:0];
                rtpg_pkg::REG_FRAME_HEIGHT: r_cfg.frame_height <= pwdata[rtpg_pkg::COORD_W-1:0];
                rtpg_pkg::REG_PAD_WIDTH:    r_cfg.pad_width    <= pwdata[rtpg_pkg::PAD_W-1:0];
                rtpg_pkg::REG_LOOP_MODE:    r_cfg.loop_mode    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (idx)
            rtpg_pkg::REG_FRAME_WIDTH:
                prdata = {{(rtpg_pkg::APB_W-rtpg_pkg::COORD_W){1'b0}}, r_cfg.frame_width};
            rtpg_pkg::REG_FRAME_HEIGHT:
                prdata = {{(rtpg_pkg::APB_W-rtpg_pkg::COORD_W){1'b0}}, r_cfg.frame_height};
            rtpg_pkg::REG_PAD_WIDTH:
                prdata = {{(rtpg_pkg::APB_W-rtpg_pkg::PAD_W){1'b0}}, r_cfg.pad_width};
            rtpg_pkg::REG_LOOP_MODE:
                prdata = {{(rtpg_pkg::APB_W-1){1'b0}}, r_cfg.loop_mode};
            default:
                prdata = '0;
        endcase
    end

endmodule

[hw/rtl/rtpg_ctrl.sv]
// Sequencing state machine of the ring test pattern generator.
// Depends on rtpg_pkg and ring_test_pattern_generator_defines.svh.
`include "ring_test_pattern_generator_defines.svh"
module rtpg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output rtpg_pkg::t_dp_cmd o_cmd
);

    rtpg_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // state and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rtpg_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            rtpg_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = rtpg_pkg::ST_GEOM;
                end
            end
            rtpg_pkg::ST_GEOM: begin
                o_cmd.geom = 1'b1;
                n_state    = rtpg_pkg::ST_SQUARE;
            end
            rtpg_pkg::ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = rtpg_pkg::ST_SHADE;
            end
            rtpg_pkg::ST_SHADE: begin
                o_cmd.shade = 1'b1;
                n_state     = rtpg_pkg::ST_FINISH;
            end
            rtpg_pkg::ST_FINISH: begin
                // wait for the output register to be free
                if (slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = rtpg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rtpg_pkg::ST_IDLE;
            end
        endcase
    end

    `RTPG_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == rtpg_pkg::ST_GEOM)
    `RTPG_ASSERT_NXT(a_finish_waits, i_clk, i_rst_n, (r_state == rtpg_pkg::ST_FINISH) && r_out_valid && !i_out_ready, r_state == rtpg_pkg::ST_FINISH)
    `RTPG_ASSERT_NXT(a_finish_shows, i_clk, i_rst_n, o_cmd.finish, r_out_valid)

endmodule

[hw/rtl/rtpg_dp.sv]
// Datapath of the ring test pattern generator: geometry, squares,
// shading and frame time. Depends on rtpg_pkg and the defines header.
`include "ring_test_pattern_generator_defines.svh"
module rtpg_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rtpg_pkg::t_cfg                 i_cfg,
    input  rtpg_pkg::t_dp_cmd              i_cmd,
    input  logic [rtpg_pkg::COORD_W-1:0]   i_pix_x,
    input  logic [rtpg_pkg::COORD_W-1:0]   i_pix_y,
    input  logic                           i_frame_last,
    input  logic [rtpg_pkg::TIME_W-1:0]    i_host_time,
    output logic [rtpg_pkg::TIME_W-1:0]    o_pixel_value,
    output logic                           o_frame_done
);

    localparam int CW = rtpg_pkg::COORD_W;
    localparam int SW = CW + 1;        // signed geometry width
    localparam int DW = CW + 2;        // signed distance width
    localparam int QW = 2 * DW - 1;    // squared distance width
    localparam int RW = QW + 1;        // r2 width
    localparam int TW = rtpg_pkg::TIME_W;
    localparam int CLW = 24;           // color width

    // input item
    logic [CW-1:0]  r_x, r_y;
    logic           r_last;
    logic [TW-1:0]  r_host;

    // geometry stage
    logic signed [SW-1:0]   r_halfw, r_halfh, r_outer_r, r_inner_r;
    logic                   r_pad, r_alpha;
    // square stage
    logic [QW-1:0]          r_dx2, r_dy2, r_osq, r_isq;
    // shade stage
    logic [CLW-1:0]         r_sum;
    // output register
    logic [TW-1:0]          r_out_pixel;
    logic                   r_out_last;
    // frame time
    logic [TW-1:0]          r_frame_time, n_frame_time;
    logic [rtpg_pkg::STEP_W-1:0] r_time_step, n_time_step;

    // geometry signals
    logic signed [SW-1:0]   diff_w, diff_h, halfw, halfh, wmp, hmp, hmin, outer_r;
    logic signed [SW-1:0]   sx, sy, d1;
    logic signed [CW+2:0]   d2;
    logic                   pad, alpha;
    // square signals
    logic signed [DW-1:0]   dx, dy;
    logic signed [2*DW-1:0] dx2_f, dy2_f;
    logic signed [2*SW-1:0] osq_f, isq_f;
    // shade signals
    logic [RW-1:0]          r2;
    logic [TW-1:0]          sum;
    // finish signals
    logic [CLW-1:0]         color;
    logic                   neg, high, low;

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x    <= i_pix_x;
            r_y    <= i_pix_y;
            r_last <= i_frame_last;
            r_host <= i_host_time;
        end
    end

    // center, radii, border and cross-line tests
    always_comb begin
        diff_w = $signed({1'b0, i_cfg.frame_width})
               - $signed({2'b0, i_cfg.pad_width, 1'b0});
        diff_h = $signed({1'b0, i_cfg.frame_height})
               - $signed({2'b0, i_cfg.pad_width, 1'b0});
        halfw  = $signed({3'b0, i_cfg.pad_width}) + (diff_w >>> 1);
        halfh  = $signed({3'b0, i_cfg.pad_width}) + (diff_h >>> 1);
        wmp    = $signed({1'b0, i_cfg.frame_width}) - $signed({3'b0, i_cfg.pad_width});
        hmp    = $signed({1'b0, i_cfg.frame_height}) - $signed({3'b0, i_cfg.pad_width});
        sx     = $signed({1'b0, r_x});
        sy     = $signed({1'b0, r_y});
        pad    = (r_x < {2'b0, i_cfg.pad_width}) || (r_y < {2'b0, i_cfg.pad_width})
              || (sx >= wmp) || (sy >= hmp);
        hmin   = (halfw < halfh) ? halfw : halfh;
        outer_r = hmin - SW'(rtpg_pkg::EDGE_GAP);
        d1     = sx - sy;
        d2     = $signed({3'b0, r_x}) + $signed({3'b0, r_y})
               - $signed({3'b0, i_cfg.frame_height});
        alpha  = ((d1 > rtpg_pkg::CROSS_HALF) || (d1 < -rtpg_pkg::CROSS_HALF))
              && ((d2 > rtpg_pkg::CROSS_HALF) || (d2 < -rtpg_pkg::CROSS_HALF));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.geom) begin
            r_halfw   <= halfw;
            r_halfh   <= halfh;
            r_outer_r <= outer_r;
            r_inner_r <= outer_r - SW'(rtpg_pkg::RING_GAP);
            r_pad     <= pad;
            r_alpha   <= alpha;
        end
    end

    // squares: four narrow multipliers in parallel
    always_comb begin
        dx    = $signed({2'b0, r_x}) - $signed({r_halfw[SW-1], r_halfw});
        dy    = $signed({2'b0, r_y}) - $signed({r_halfh[SW-1], r_halfh});
        dx2_f = dx * dx;
        dy2_f = dy * dy;
        osq_f = r_outer_r * r_outer_r;
        isq_f = r_inner_r * r_inner_r;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.square) begin
            r_dx2 <= dx2_f[QW-1:0];
            r_dy2 <= dy2_f[QW-1:0];
            r_osq <= QW'(osq_f[2*SW-2:0]);
            r_isq <= QW'(isq_f[2*SW-2:0]);
        end
    end

    // region select and time offset
    always_comb begin
        r2 = {1'b0, r_dx2} + {1'b0, r_dy2};
        if (r2 < {1'b0, r_isq}) begin
            sum = TW'(r2 >> 5) + (r_frame_time >> 6);
        end else if (r2 < {1'b0, r_osq}) begin
            sum = {{(TW-CW){1'b0}}, r_y} + (r_frame_time >> 5);
        end else begin
            sum = {{(TW-CW){1'b0}}, r_x} + (r_frame_time >> 4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shade) begin
            r_sum <= sum[CLW-1:0];
        end
    end

    // color scale: 0x0080401 = 2^19 + 2^10 + 1, kept to 24 bits
    assign color = r_sum + (r_sum << 10) + (r_sum << 19);

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_pixel <= r_pad ? rtpg_pkg::PAD_VALUE
                                 : {(r_alpha ? rtpg_pkg::ALPHA_ON : 8'h00), color};
            r_out_last  <= r_last;
        end
    end

    assign o_pixel_value = r_out_pixel;
    assign o_frame_done  = r_out_last;

    // frame time update on the last pixel of a frame
    always_comb begin
        neg          = r_frame_time[TW-1];
        high         = !neg && (r_frame_time >= TW'(rtpg_pkg::LOOP_HIGH));
        low          = neg || (r_frame_time < TW'(rtpg_pkg::LOOP_LOW));
        n_time_step  = r_time_step;
        n_frame_time = r_frame_time;
        if (i_cmd.finish && r_last) begin
            if (i_cfg.loop_mode) begin
                if (high || low) begin
                    n_time_step = -r_time_step;
                end
                n_frame_time = r_frame_time
                             + {{(TW-rtpg_pkg::STEP_W){n_time_step[rtpg_pkg::STEP_W-1]}},
                                n_time_step};
            end else begin
                n_frame_time = r_host;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_time <= '0;
            r_time_step  <= rtpg_pkg::STEP_RESET;
        end else begin
            r_frame_time <= n_frame_time;
            r_time_step  <= n_time_step;
        end
    end

    `RTPG_ASSERT_IMP(a_step_mag, i_clk, i_rst_n, 1'b1,
        (r_time_step == 6'sd16) || (r_time_step == rtpg_pkg::STEP_RESET))
    `RTPG_ASSERT_NXT(a_loop_moves, i_clk, i_rst_n, i_cfg.loop_mode && i_cmd.finish && r_last,
        (r_frame_time == $past(r_frame_time) + 32'd16)
        || (r_frame_time == $past(r_frame_time) - 32'd16))
    `RTPG_ASSERT_NXT(a_time_holds, i_clk, i_rst_n, !(i_cmd.finish && r_last),
        $stable(r_frame_time))

endmodule
